// ===== rtl/sdes_pkg.sv =====
// Package: bit permutations, S-box tables and key schedule for the S-DES byte cipher.
package sdes_pkg;

    // Register map, word addresses (byte address / 4)
    localparam logic REG_CIPHER_KEY = 1'b0;

    localparam int unsigned KEY_W  = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HALF_W = 4;
    localparam int unsigned SUBK_W = 8;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // S-boxes, indexed by {row, col}; row = outer bits, col = inner bits
    localparam logic [1:0] SBOX_A [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd0, 2'd2
    };
    localparam logic [1:0] SBOX_B [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd3, 2'd1, 2'd0,
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic logic [9:0] perm_p10(input logic [9:0] k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic logic [7:0] perm_p8(input logic [9:0] x);
        return {x[4], x[7], x[3], x[6], x[2], x[5], x[0], x[1]};
    endfunction

    function automatic logic [7:0] perm_ip(input logic [7:0] b);
        return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
    endfunction

    function automatic logic [7:0] perm_ipinv(input logic [7:0] b);
        return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
    endfunction

    function automatic logic [7:0] perm_ep(input logic [3:0] h);
        return {h[0], h[3], h[2], h[1], h[2], h[1], h[0], h[3]};
    endfunction

    function automatic logic [3:0] perm_p4(input logic [3:0] s);
        return {s[2], s[0], s[1], s[3]};
    endfunction

    function automatic logic [3:0] sbox_idx(input logic [3:0] n);
        return {n[3], n[0], n[2], n[1]};
    endfunction

    function automatic logic [4:0] rotl1(input logic [4:0] v);
        return {v[3:0], v[4]};
    endfunction

    function automatic logic [4:0] rotl2(input logic [4:0] v);
        return {v[2:0], v[4:3]};
    endfunction

    // Both subkeys start from the P10 result (no cumulative shift)
    function automatic logic [7:0] subkey1(input logic [9:0] key);
        logic [9:0] p;
        p = perm_p10(key);
        return perm_p8({rotl1(p[9:5]), rotl1(p[4:0])});
    endfunction

    function automatic logic [7:0] subkey2(input logic [9:0] key);
        logic [9:0] p;
        p = perm_p10(key);
        return perm_p8({rotl2(p[9:5]), rotl2(p[4:0])});
    endfunction

endpackage

// ===== rtl/sdes_round.sv =====
// One Feistel half-round: xor_in ^ P4(S(EP(half_in) ^ subkey)).
module sdes_round
(
    input  logic [sdes_pkg::HALF_W-1:0] half_in,
    input  logic [sdes_pkg::HALF_W-1:0] xor_in,
    input  logic [sdes_pkg::SUBK_W-1:0] subkey,
    output logic [sdes_pkg::HALF_W-1:0] half_out
);
    import sdes_pkg::*;

    logic [SUBK_W-1:0] mixed;
    logic [HALF_W-1:0] sbox_out;

    // expansion and key mix
    assign mixed = perm_ep(half_in) ^ subkey;

    // substitution, left box on the upper nibble
    assign sbox_out = {SBOX_A[sbox_idx(mixed[7:4])], SBOX_B[sbox_idx(mixed[3:0])]};

    assign half_out = xor_in ^ perm_p4(sbox_out);

endmodule

// ===== rtl/sdes_byte_encrypt.sv =====
// Top level: three-stage pipelined S-DES byte encryption with APB key register.
// Each accepted input beat passes the stage 1, 2 and 3 registers in turn to the output beat.
// Throughput: one beat per cycle while m_tready does not stall the output; stage 1 = IP and round 1, stage 2 = round 2,
// stage 3 = IP inverse into the output register.
// Reset: rst_n asynchronously clears all valid bits and the key to zero;
// subkeys are recomputed and registered on each key write.
module sdes_byte_encrypt
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdes_pkg::APB_AW-1:0]   paddr,
    input  logic [sdes_pkg::APB_DW-1:0]   pwdata,
    output logic [sdes_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sdes_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] plain_byte
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdes_pkg::BYTE_W-1:0]   m_tdata    // [7:0] cipher_byte
);
    import sdes_pkg::*;

    logic [KEY_W-1:0]  cipher_key_reg;
    logic [SUBK_W-1:0] k1_reg;
    logic [SUBK_W-1:0] k2_reg;
    logic              key_wr;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [HALF_W-1:0] s1_l1_reg, s1_r0_reg;
    logic [HALF_W-1:0] s2_l2_reg, s2_l1_reg;
    logic [BYTE_W-1:0] s3_data_reg;

    logic              adv1, adv2, adv3;
    logic [BYTE_W-1:0] ip_in;
    logic [HALF_W-1:0] s1_l1_next, s2_l2_next;
    logic [BYTE_W-1:0] s3_data_next;

    // configuration access
    assign pready = 1'b1;
    assign key_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CIPHER_KEY);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CIPHER_KEY)
        begin
            prdata = {{(APB_DW-KEY_W){1'b0}}, cipher_key_reg};
        end
    end

    // key and subkeys, refreshed on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
            k1_reg         <= subkey1('0);
            k2_reg         <= subkey2('0);
        end
        else if (key_wr)
        begin
            cipher_key_reg <= pwdata[KEY_W-1:0];
            k1_reg         <= subkey1(pwdata[KEY_W-1:0]);
            k2_reg         <= subkey2(pwdata[KEY_W-1:0]);
        end
    end

    // pipeline advance: a stage moves when empty or when the next one moves
    assign adv3     = !s3_valid_reg || m_tready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_tready = adv1;

    // stage 1 datapath: IP and first round
    assign ip_in = perm_ip(s_tdata);

    sdes_round u_round1
    (
        .half_in  (ip_in[3:0]),
        .xor_in   (ip_in[7:4]),
        .subkey   (k1_reg),
        .half_out (s1_l1_next)
    );

    // stage 2 datapath: second round
    sdes_round u_round2
    (
        .half_in  (s1_l1_reg),
        .xor_in   (s1_r0_reg),
        .subkey   (k2_reg),
        .half_out (s2_l2_next)
    );

    // stage 3 datapath: inverse IP
    assign s3_data_next = perm_ipinv({s2_l2_reg, s2_l1_reg});

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_l1_reg <= s1_l1_next;
            s1_r0_reg <= ip_in[3:0];
        end
        if (adv2)
        begin
            s2_l2_reg <= s2_l2_next;
            s2_l1_reg <= s1_l1_reg;
        end
        if (adv3)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = s3_data_reg;

endmodule

// ===== rtl/sdes_checker.sv =====
// Port-level checker for sdes_byte_encrypt and its bind.
module sdes_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sdes_pkg::BYTE_W-1:0] m_tdata
);
    import sdes_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

    // no back-pressure when the sink is ready
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // an accepted beat reaches the output while the sink stays ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("output beat missing after three cycles");

    // pipeline drains once the input has stayed idle with a ready sink
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready)
        |=> !m_tvalid)
        else $error("output beat without input");

endmodule

bind sdes_byte_encrypt sdes_checker u_sdes_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
